FILE: src/text_console_cursor_engine_top_defines.svh
// assertion macros for the text console cursor engine
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TCCE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tcce assertion failed");
`define TCCE_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("tcce assertion failed");
`else
`define TCCE_ASSERT(lbl, clk, rst, prop)
`define TCCE_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: src/tcce_pkg.sv
// shared types and constants of the text console cursor engine
package tcce_pkg;

   typedef enum logic [1:0] {
      OP_CHAR      = 2'd0,
      OP_BACKSPACE = 2'd1,
      OP_NEWLINE   = 2'd2,
      OP_CLEAR     = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CMD_ERASE  = 3'd0,
      CMD_DRAW   = 3'd1,
      CMD_GLYPH  = 3'd2,
      CMD_FILL   = 3'd3,
      CMD_SCROLL = 3'd4,
      CMD_CLEAR  = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      REG_WIN_LEFT    = 3'd0,
      REG_WIN_RIGHT   = 3'd1,
      REG_WIN_TOP     = 3'd2,
      REG_WIN_BOTTOM  = 3'd3,
      REG_CHAR_WIDTH  = 3'd4,
      REG_CHAR_HEIGHT = 3'd5
   } reg_idx_type;

   localparam int RUN_DEPTH     = 5;
   localparam int RUN_IDX_BITS  = 3;
   localparam int SIZE_BITS     = 7;
   localparam int GLYPH_BITS    = 7;
   localparam int CODE_BITS     = 16;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CODE_BITS-1:0] CHAR_FIRST = 16'h0020;
   localparam logic [CODE_BITS-1:0] CHAR_LAST  = 16'h007F;

   localparam logic [SIZE_BITS-1:0] CHAR_WIDTH_RESET  = 7'd8;
   localparam logic [SIZE_BITS-1:0] CHAR_HEIGHT_RESET = 7'd8;

   typedef struct packed {
      logic [RUN_IDX_BITS-1:0] count;
      logic                    shown;
   } run_ctl_type;

endpackage

FILE: src/tcce_csr.sv
// apb register file holding the console window and font cell geometry
module tcce_csr #(
   parameter int COORD_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [tcce_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [tcce_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [tcce_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready,
   output logic [COORD_BITS-1:0]                win_left,
   output logic [COORD_BITS-1:0]                win_right,
   output logic [COORD_BITS-1:0]                win_top,
   output logic [COORD_BITS-1:0]                win_bottom,
   output logic [tcce_pkg::SIZE_BITS-1:0]       char_width,
   output logic [tcce_pkg::SIZE_BITS-1:0]       char_height
);
   import tcce_pkg::*;

   localparam logic [COORD_BITS-1:0] WIN_RIGHT_RESET  = COORD_BITS'(639);
   localparam logic [COORD_BITS-1:0] WIN_BOTTOM_RESET = COORD_BITS'(479);

   logic [COORD_BITS-1:0] left_ff, left_in;
   logic [COORD_BITS-1:0] right_ff, right_in;
   logic [COORD_BITS-1:0] top_ff, top_in;
   logic [COORD_BITS-1:0] bottom_ff, bottom_in;
   logic [SIZE_BITS-1:0]  width_ff, width_in;
   logic [SIZE_BITS-1:0]  height_ff, height_in;
   logic                  wr_en;
   reg_idx_type           reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = reg_idx_type'(paddr[4:2]);

   always_comb begin
      left_in   = left_ff;
      right_in  = right_ff;
      top_in    = top_ff;
      bottom_in = bottom_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_WIN_LEFT: begin
               left_in = pwdata[COORD_BITS-1:0];
            end
            REG_WIN_RIGHT: begin
               right_in = pwdata[COORD_BITS-1:0];
            end
            REG_WIN_TOP: begin
               top_in = pwdata[COORD_BITS-1:0];
            end
            REG_WIN_BOTTOM: begin
               bottom_in = pwdata[COORD_BITS-1:0];
            end
            REG_CHAR_WIDTH: begin
               width_in = pwdata[SIZE_BITS-1:0];
            end
            REG_CHAR_HEIGHT: begin
               height_in = pwdata[SIZE_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         right_ff  <= WIN_RIGHT_RESET;
         top_ff    <= '0;
         bottom_ff <= WIN_BOTTOM_RESET;
         width_ff  <= CHAR_WIDTH_RESET;
         height_ff <= CHAR_HEIGHT_RESET;
      end else begin
         left_ff   <= left_in;
         right_ff  <= right_in;
         top_ff    <= top_in;
         bottom_ff <= bottom_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_WIN_LEFT:    prdata = CSR_DATA_BITS'(left_ff);
         REG_WIN_RIGHT:   prdata = CSR_DATA_BITS'(right_ff);
         REG_WIN_TOP:     prdata = CSR_DATA_BITS'(top_ff);
         REG_WIN_BOTTOM:  prdata = CSR_DATA_BITS'(bottom_ff);
         REG_CHAR_WIDTH:  prdata = CSR_DATA_BITS'(width_ff);
         REG_CHAR_HEIGHT: prdata = CSR_DATA_BITS'(height_ff);
         default:         prdata = '0;
      endcase
   end

   assign win_left    = left_ff;
   assign win_right   = right_ff;
   assign win_top     = top_ff;
   assign win_bottom  = bottom_ff;
   assign char_width  = width_ff;
   assign char_height = height_ff;

endmodule

FILE: src/tcce_run_gen.sv
// builds the full command run of one transaction and the next cursor state
module tcce_run_gen #(
   parameter int COORD_BITS = 12
) (
   input  tcce_pkg::op_type                     op_i,
   input  logic [tcce_pkg::CODE_BITS-1:0]       code_i,
   input  logic [COORD_BITS-1:0]                col_i,
   input  logic [COORD_BITS-1:0]                row_i,
   input  logic                                 shown_i,
   input  logic [COORD_BITS-1:0]                win_left,
   input  logic [COORD_BITS-1:0]                win_right,
   input  logic [COORD_BITS-1:0]                win_top,
   input  logic [COORD_BITS-1:0]                win_bottom,
   input  logic [tcce_pkg::SIZE_BITS-1:0]       char_width,
   input  logic [tcce_pkg::SIZE_BITS-1:0]       char_height,
   output tcce_pkg::cmd_type                    cmd_o   [tcce_pkg::RUN_DEPTH],
   output logic [COORD_BITS-1:0]                xs_o    [tcce_pkg::RUN_DEPTH],
   output logic [COORD_BITS-1:0]                ys_o    [tcce_pkg::RUN_DEPTH],
   output logic [COORD_BITS-1:0]                xe_o    [tcce_pkg::RUN_DEPTH],
   output logic [COORD_BITS-1:0]                ye_o    [tcce_pkg::RUN_DEPTH],
   output logic [tcce_pkg::GLYPH_BITS-1:0]      glyph_o [tcce_pkg::RUN_DEPTH],
   output logic [tcce_pkg::SIZE_BITS-1:0]       rows_o  [tcce_pkg::RUN_DEPTH],
   output logic [COORD_BITS-1:0]                col_o,
   output logic [COORD_BITS-1:0]                row_o,
   output tcce_pkg::run_ctl_type                ctl_o
);
   import tcce_pkg::*;

   localparam int FW = COORD_BITS + 2;
   localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

   logic [COORD_BITS-1:0]   col_v;
   logic [COORD_BITS-1:0]   row_v;
   logic [COORD_BITS-1:0]   w_c;
   logic [COORD_BITS-1:0]   h_c;
   logic [RUN_IDX_BITS-1:0] n_v;
   logic                    printable;

   function automatic logic fits(input logic [COORD_BITS-1:0] col,
                                 input logic [COORD_BITS-1:0] left,
                                 input logic [COORD_BITS-1:0] right,
                                 input logic [SIZE_BITS-1:0]  width);
      logic [FW-1:0] span;
      logic [FW-1:0] limit;
      span  = FW'(col) + FW'(left) + FW'(width);
      limit = FW'(right) + FW'(1);
      return span <= limit;
   endfunction

   // row after the step down; the scroll keeps it on the last text row
   function automatic logic [COORD_BITS-1:0] nl_row(input logic [COORD_BITS-1:0] row,
                                                   input logic [COORD_BITS-1:0] h,
                                                   input logic                  scroll);
      logic [COORD_BITS-1:0] down;
      down = row + h;
      return scroll ? row : down;
   endfunction

   function automatic logic nl_scroll(input logic [COORD_BITS-1:0] row,
                                      input logic [COORD_BITS-1:0] h,
                                      input logic [COORD_BITS-1:0] top,
                                      input logic [COORD_BITS-1:0] bottom);
      logic [COORD_BITS-1:0] down;
      logic [FW-1:0]         abs_y;
      down  = row + h;
      abs_y = FW'(top) + FW'(down);
      return abs_y >= FW'(bottom);
   endfunction

   assign w_c = COORD_BITS'(char_width);
   assign h_c = COORD_BITS'(char_height);
   assign printable = (code_i >= CHAR_FIRST) && (code_i <= CHAR_LAST);

   always_comb begin
      col_v       = col_i;
      row_v       = row_i;
      n_v         = '0;
      ctl_o.shown = shown_i;
      for (int i = 0; i < RUN_DEPTH; i++) begin
         cmd_o[i]   = CMD_ERASE;
         xs_o[i]    = '0;
         ys_o[i]    = '0;
         xe_o[i]    = '0;
         ye_o[i]    = '0;
         glyph_o[i] = '0;
         rows_o[i]  = '0;
      end
      if (op_i == OP_CLEAR) begin
         cmd_o[0]    = CMD_CLEAR;
         xs_o[0]     = win_left;
         ys_o[0]     = win_top;
         xe_o[0]     = win_right;
         ye_o[0]     = win_bottom;
         n_v         = RUN_IDX_BITS'(1);
         col_v       = '0;
         row_v       = '0;
         ctl_o.shown = 1'b0;
      end else begin
         if (shown_i) begin
            cmd_o[n_v] = CMD_ERASE;
            xs_o[n_v]  = win_left + col_v;
            ys_o[n_v]  = win_top + row_v;
            xe_o[n_v]  = win_left + col_v;
            ye_o[n_v]  = win_top + row_v + h_c - ONE;
            n_v        = n_v + RUN_IDX_BITS'(1);
         end
         case (op_i)
            OP_BACKSPACE: begin
               if (!((col_v == '0) && (row_v == '0))) begin
                  if (col_v == '0) begin
                     col_v = win_right - win_left + ONE;
                     row_v = row_v - h_c;
                  end
                  col_v      = col_v - w_c;
                  cmd_o[n_v] = CMD_FILL;
                  xs_o[n_v]  = win_left + col_v;
                  ys_o[n_v]  = win_top + row_v;
                  xe_o[n_v]  = win_left + col_v + w_c - ONE;
                  ye_o[n_v]  = win_top + row_v + h_c - ONE;
                  n_v        = n_v + RUN_IDX_BITS'(1);
               end
            end
            OP_NEWLINE: begin
               col_v = '0;
               if (nl_scroll(row_v, h_c, win_top, win_bottom)) begin
                  cmd_o[n_v]  = CMD_SCROLL;
                  xs_o[n_v]   = win_left;
                  ys_o[n_v]   = win_top;
                  xe_o[n_v]   = win_right;
                  ye_o[n_v]   = win_bottom;
                  rows_o[n_v] = char_height;
                  n_v         = n_v + RUN_IDX_BITS'(1);
                  row_v       = nl_row(row_v, h_c, 1'b1);
               end else begin
                  row_v = nl_row(row_v, h_c, 1'b0);
               end
            end
            OP_CHAR: begin
               if (printable) begin
                  if (fits(col_v, win_left, win_right, char_width)) begin
                     cmd_o[n_v]   = CMD_GLYPH;
                     xs_o[n_v]    = win_left + col_v;
                     ys_o[n_v]    = win_top + row_v;
                     glyph_o[n_v] = code_i[GLYPH_BITS-1:0];
                     n_v          = n_v + RUN_IDX_BITS'(1);
                     col_v        = col_v + w_c;
                  end else begin
                     // wrap to a fresh line, draw the cursor there, then retry once
                     col_v = '0;
                     if (nl_scroll(row_v, h_c, win_top, win_bottom)) begin
                        cmd_o[n_v]  = CMD_SCROLL;
                        xs_o[n_v]   = win_left;
                        ys_o[n_v]   = win_top;
                        xe_o[n_v]   = win_right;
                        ye_o[n_v]   = win_bottom;
                        rows_o[n_v] = char_height;
                        n_v         = n_v + RUN_IDX_BITS'(1);
                        row_v       = nl_row(row_v, h_c, 1'b1);
                     end else begin
                        row_v = nl_row(row_v, h_c, 1'b0);
                     end
                     cmd_o[n_v] = CMD_DRAW;
                     xs_o[n_v]  = win_left;
                     ys_o[n_v]  = win_top + row_v;
                     xe_o[n_v]  = win_left;
                     ye_o[n_v]  = win_top + row_v + h_c - ONE;
                     n_v        = n_v + RUN_IDX_BITS'(1);
                     if (fits(col_v, win_left, win_right, char_width)) begin
                        cmd_o[n_v]   = CMD_GLYPH;
                        xs_o[n_v]    = win_left;
                        ys_o[n_v]    = win_top + row_v;
                        glyph_o[n_v] = code_i[GLYPH_BITS-1:0];
                        n_v          = n_v + RUN_IDX_BITS'(1);
                        col_v        = w_c;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
         cmd_o[n_v]  = CMD_DRAW;
         xs_o[n_v]   = win_left + col_v;
         ys_o[n_v]   = win_top + row_v;
         xe_o[n_v]   = win_left + col_v;
         ye_o[n_v]   = win_top + row_v + h_c - ONE;
         n_v         = n_v + RUN_IDX_BITS'(1);
         ctl_o.shown = 1'b1;
      end
      ctl_o.count = n_v;
      col_o       = col_v;
      row_o       = row_v;
   end

endmodule

FILE: src/text_console_cursor_engine_top.sv
// top level of the text console cursor engine
// Each accepted transaction (character, backspace, newline or clear) turns into a run of
// one to five drawing commands on the rsp channel, one command per cycle unless rsp_stall
// is high, the final one flagged by rsp_last; a clear gives one command, a plain character
// two or three, and a character that wraps and scrolls up to five. An item waits in the
// input register while the previous run drains; its whole run is computed combinationally
// and loaded into the run buffer as the last command of the previous run is taken. Window
// and cell geometry registers sit on the apb port and must be written only while the engine
// is idle; the user is bound to this, as the block itself does not enforce it.
`include "text_console_cursor_engine_top_defines.svh"
module text_console_cursor_engine_top #(
   parameter int COORD_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_op,
   input  logic [tcce_pkg::CODE_BITS-1:0]       req_char_code,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [2:0]                           rsp_cmd,
   output logic [COORD_BITS-1:0]                rsp_x_start,
   output logic [COORD_BITS-1:0]                rsp_y_start,
   output logic [COORD_BITS-1:0]                rsp_x_end,
   output logic [COORD_BITS-1:0]                rsp_y_end,
   output logic [tcce_pkg::GLYPH_BITS-1:0]      rsp_glyph,
   output logic [tcce_pkg::SIZE_BITS-1:0]       rsp_scroll_rows,
   output logic                                 rsp_last,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [tcce_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [tcce_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [tcce_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready
);
   import tcce_pkg::*;

   logic [COORD_BITS-1:0] win_left;
   logic [COORD_BITS-1:0] win_right;
   logic [COORD_BITS-1:0] win_top;
   logic [COORD_BITS-1:0] win_bottom;
   logic [SIZE_BITS-1:0]  char_width;
   logic [SIZE_BITS-1:0]  char_height;

   // input register
   logic                  item_valid_ff, item_valid_in;
   op_type                item_op_ff, item_op_in;
   logic [CODE_BITS-1:0]  item_code_ff, item_code_in;

   // cursor state
   logic [COORD_BITS-1:0] col_ff, col_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic                  shown_ff, shown_in;

   // run buffer
   logic                    run_valid_ff, run_valid_in;
   logic [RUN_IDX_BITS-1:0] run_cnt_ff, run_cnt_in;
   logic [RUN_IDX_BITS-1:0] run_idx_ff, run_idx_in;
   cmd_type                 run_cmd_ff   [RUN_DEPTH];
   logic [COORD_BITS-1:0]   run_xs_ff    [RUN_DEPTH];
   logic [COORD_BITS-1:0]   run_ys_ff    [RUN_DEPTH];
   logic [COORD_BITS-1:0]   run_xe_ff    [RUN_DEPTH];
   logic [COORD_BITS-1:0]   run_ye_ff    [RUN_DEPTH];
   logic [GLYPH_BITS-1:0]   run_glyph_ff [RUN_DEPTH];
   logic [SIZE_BITS-1:0]    run_rows_ff  [RUN_DEPTH];

   cmd_type                 gen_cmd   [RUN_DEPTH];
   logic [COORD_BITS-1:0]   gen_xs    [RUN_DEPTH];
   logic [COORD_BITS-1:0]   gen_ys    [RUN_DEPTH];
   logic [COORD_BITS-1:0]   gen_xe    [RUN_DEPTH];
   logic [COORD_BITS-1:0]   gen_ye    [RUN_DEPTH];
   logic [GLYPH_BITS-1:0]   gen_glyph [RUN_DEPTH];
   logic [SIZE_BITS-1:0]    gen_rows  [RUN_DEPTH];
   logic [COORD_BITS-1:0]   gen_col;
   logic [COORD_BITS-1:0]   gen_row;
   run_ctl_type             gen_ctl;

   logic req_take;
   logic rsp_take;
   logic run_done;
   logic load_run;

   tcce_csr #(
      .COORD_BITS (COORD_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .win_left    (win_left),
      .win_right   (win_right),
      .win_top     (win_top),
      .win_bottom  (win_bottom),
      .char_width  (char_width),
      .char_height (char_height)
   );

   tcce_run_gen #(
      .COORD_BITS (COORD_BITS)
   ) u_run_gen (
      .op_i        (item_op_ff),
      .code_i      (item_code_ff),
      .col_i       (col_ff),
      .row_i       (row_ff),
      .shown_i     (shown_ff),
      .win_left    (win_left),
      .win_right   (win_right),
      .win_top     (win_top),
      .win_bottom  (win_bottom),
      .char_width  (char_width),
      .char_height (char_height),
      .cmd_o       (gen_cmd),
      .xs_o        (gen_xs),
      .ys_o        (gen_ys),
      .xe_o        (gen_xe),
      .ye_o        (gen_ye),
      .glyph_o     (gen_glyph),
      .rows_o      (gen_rows),
      .col_o       (gen_col),
      .row_o       (gen_row),
      .ctl_o       (gen_ctl)
   );

   assign rsp_valid = run_valid_ff;
   assign rsp_last  = (run_idx_ff == (run_cnt_ff - RUN_IDX_BITS'(1)));
   assign rsp_take  = run_valid_ff && !rsp_stall;
   assign run_done  = rsp_take && rsp_last;
   assign load_run  = item_valid_ff && (!run_valid_ff || run_done);
   assign req_stall = item_valid_ff && !load_run;
   assign req_take  = req_valid && !req_stall;

   assign rsp_cmd         = run_cmd_ff[run_idx_ff];
   assign rsp_x_start     = run_xs_ff[run_idx_ff];
   assign rsp_y_start     = run_ys_ff[run_idx_ff];
   assign rsp_x_end       = run_xe_ff[run_idx_ff];
   assign rsp_y_end       = run_ye_ff[run_idx_ff];
   assign rsp_glyph       = run_glyph_ff[run_idx_ff];
   assign rsp_scroll_rows = run_rows_ff[run_idx_ff];

   always_comb begin
      item_valid_in = item_valid_ff;
      item_op_in    = item_op_ff;
      item_code_in  = item_code_ff;
      if (req_take) begin
         item_valid_in = 1'b1;
         item_op_in    = op_type'(req_op);
         item_code_in  = req_char_code;
      end else if (load_run) begin
         item_valid_in = 1'b0;
      end
   end

   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      shown_in     = shown_ff;
      run_valid_in = run_valid_ff;
      run_cnt_in   = run_cnt_ff;
      run_idx_in   = run_idx_ff;
      if (load_run) begin
         col_in       = gen_col;
         row_in       = gen_row;
         shown_in     = gen_ctl.shown;
         run_valid_in = 1'b1;
         run_cnt_in   = gen_ctl.count;
         run_idx_in   = '0;
      end else if (run_done) begin
         run_valid_in = 1'b0;
      end else if (rsp_take) begin
         run_idx_in = run_idx_ff + RUN_IDX_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         col_ff        <= '0;
         row_ff        <= '0;
         shown_ff      <= 1'b0;
         run_valid_ff  <= 1'b0;
         run_cnt_ff    <= '0;
         run_idx_ff    <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         shown_ff      <= shown_in;
         run_valid_ff  <= run_valid_in;
         run_cnt_ff    <= run_cnt_in;
         run_idx_ff    <= run_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      item_op_ff   <= item_op_in;
      item_code_ff <= item_code_in;
      if (load_run) begin
         run_cmd_ff   <= gen_cmd;
         run_xs_ff    <= gen_xs;
         run_ys_ff    <= gen_ys;
         run_xe_ff    <= gen_xe;
         run_ye_ff    <= gen_ye;
         run_glyph_ff <= gen_glyph;
         run_rows_ff  <= gen_rows;
      end
   end

   `TCCE_ASSERT(a_run_count, clock, reset, run_valid_ff |-> ((run_cnt_ff != '0) && (run_cnt_ff <= RUN_IDX_BITS'(RUN_DEPTH))))
   `TCCE_ASSERT(a_run_index, clock, reset, run_valid_ff |-> (run_idx_ff < run_cnt_ff))
   `TCCE_ASSERT(a_run_ends, clock, reset, (run_done && !load_run) |=> !run_valid_ff)
   `TCCE_ASSERT(a_cursor_drawn, clock, reset, (load_run && (item_op_ff != OP_CLEAR)) |=> shown_ff)
   `TCCE_ASSERT(a_clear_single, clock, reset, (load_run && (item_op_ff == OP_CLEAR)) |=> ((run_cnt_ff == RUN_IDX_BITS'(1)) && !shown_ff && (col_ff == '0) && (row_ff == '0)))
   `TCCE_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!run_valid_ff && !item_valid_ff))

endmodule
